[hw/rtl/mefb_pkg.sv]
package mefb_pkg;

    // default geometry of the encoder and of the angle accumulator
    localparam int ENC_COUNTS_DEF  = 8192;
    localparam int ANGLE_BITS_DEF  = 40;

    // register reset values
    localparam logic [14:0] CUR_LIMIT_RST   = 15'd30000;
    localparam logic [15:0] TIMEOUT_MS_RST  = 16'd500;

    // only frames of this length code are taken
    localparam logic [3:0] FRAME_LEN_OK = 4'd8;

    // register map, word index taken from paddr[2]
    localparam int          PADDR_W         = 3;
    localparam logic [0:0]  REG_CUR_LIMIT   = 1'b0;
    localparam logic [0:0]  REG_TIMEOUT_MS  = 1'b1;

    // fixed field widths
    localparam int ANGLE_OUT_W = 40;
    localparam int SPEED_W     = 19;
    localparam int POS_W       = 13;

    // input transfer layout
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 2;
    localparam int S_LEN_LSB = 0;
    localparam int S_ENC_LSB = 4;
    localparam int S_SPD_LSB = 20;
    localparam int S_CUR_LSB = 36;
    localparam int S_FTM_LSB = 52;
    localparam int S_NOW_LSB = 84;
    localparam int S_REQ_LSB = 116;

    // result transfer layout
    localparam int M_TDATA_W  = 112;
    localparam int M_TUSER_W  = 1;
    localparam int M_ANG_LSB  = 0;
    localparam int M_SPD_LSB  = 40;
    localparam int M_CUR_LSB  = 59;
    localparam int M_POS_LSB  = 75;
    localparam int M_SEEN_BIT = 88;
    localparam int M_ONL_BIT  = 89;
    localparam int M_TGT_LSB  = 90;
    localparam int M_PAD_LSB  = 106;

endpackage

[hw/rtl/multiturn_encoder_feedback_tracker_top.sv]
// a result passes the input register and then the result register before it is offered
// throughput: one item per cycle, sustained while the result side keeps m_tready high
// the state update and the result are formed in a single pass from the input register
// reset (aresetn low, synchronous): registers return to current limit 30000, timeout_ms 500,
// all tracking state clears to zero and both channels empty
module multiturn_encoder_feedback_tracker_top #(
    parameter int ENC_COUNTS = mefb_pkg::ENC_COUNTS_DEF,
    parameter int ANGLE_BITS = mefb_pkg::ANGLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_length[3:0], enc_field[19:4], speed_rpm[35:20], motor_current[51:36],
    // frame_time_ms[83:52], now_ms[115:84], requested_current[131:116], zero[135:132]
    input  logic [mefb_pkg::S_TDATA_W-1:0]   s_tdata,
    // frame_present[0], write_target[1]
    input  logic [mefb_pkg::S_TUSER_W-1:0]   s_tuser,

    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // angle_counts[39:0], speed_deg[58:40], current_out[74:59], encoder_position[87:75],
    // feedback_seen[88], online[89], drive_tgt[105:90], zero[111:106]
    output logic [mefb_pkg::M_TDATA_W-1:0]   m_tdata,
    // frame_accepted[0]
    output logic [mefb_pkg::M_TUSER_W-1:0]   m_tuser,

    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mefb_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int ENC_W = $clog2(ENC_COUNTS);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [14:0] cur_limit_reg;
    logic [15:0] timeout_ms_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_limit_reg  <= mefb_pkg::CUR_LIMIT_RST;
            timeout_ms_reg <= mefb_pkg::TIMEOUT_MS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mefb_pkg::REG_CUR_LIMIT:  cur_limit_reg  <= pwdata[14:0];
                mefb_pkg::REG_TIMEOUT_MS: timeout_ms_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back, low address bits ignored
    always_comb begin
        unique case (paddr[2])
            mefb_pkg::REG_CUR_LIMIT:  prdata = {17'b0, cur_limit_reg};
            mefb_pkg::REG_TIMEOUT_MS: prdata = {16'b0, timeout_ms_reg};
            default:                  prdata = 32'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: input register feeds the result register directly,
    // the input side takes a transfer when it holds no item or the item it holds moves on
    // ---------------------------------------------------------------
    logic                           in_valid_reg;
    logic [mefb_pkg::S_TDATA_W-1:0] in_tdata_reg;
    logic [mefb_pkg::S_TUSER_W-1:0] in_tuser_reg;
    logic                           out_valid_reg;
    logic [mefb_pkg::M_TDATA_W-1:0] out_tdata_reg;
    logic [mefb_pkg::M_TUSER_W-1:0] out_tuser_reg;
    logic                           advance;
    logic                           s_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_tdata_reg <= s_tdata;
            in_tuser_reg <= s_tuser;
        end
    end

    // unpack the held item
    logic                frame_present;
    logic                write_target;
    logic [3:0]          frame_length;
    logic [15:0]         enc_field;
    logic signed [15:0]  speed_rpm;
    logic signed [15:0]  motor_current;
    logic [31:0]         frame_time_ms;
    logic [31:0]         now_ms;
    logic signed [15:0]  requested_current;

    assign frame_present     = in_tuser_reg[0];
    assign write_target      = in_tuser_reg[1];
    assign frame_length      = in_tdata_reg[mefb_pkg::S_LEN_LSB +: 4];
    assign enc_field         = in_tdata_reg[mefb_pkg::S_ENC_LSB +: 16];
    assign speed_rpm         = signed'(in_tdata_reg[mefb_pkg::S_SPD_LSB +: 16]);
    assign motor_current     = signed'(in_tdata_reg[mefb_pkg::S_CUR_LSB +: 16]);
    assign frame_time_ms     = in_tdata_reg[mefb_pkg::S_FTM_LSB +: 32];
    assign now_ms            = in_tdata_reg[mefb_pkg::S_NOW_LSB +: 32];
    assign requested_current = signed'(in_tdata_reg[mefb_pkg::S_REQ_LSB +: 16]);

    // ---------------------------------------------------------------
    // tracking state, updated as each item moves into the result register
    // ---------------------------------------------------------------
    logic [ENC_W-1:0]                     last_enc_reg,  last_enc_next;
    logic signed [ANGLE_BITS-1:0]         angle_reg,     angle_next;
    logic signed [mefb_pkg::SPEED_W-1:0]  speed_reg,     speed_next;
    logic signed [15:0]                   current_reg,   current_next;
    logic [31:0]                          last_time_reg, last_time_next;
    logic                                 seen_reg,      seen_next;
    logic signed [15:0]                   target_reg,    target_next;
    logic                                 accepted;
    logic                                 online;

    mefb_update #(
        .ENC_COUNTS (ENC_COUNTS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_update (
        .frame_present     (frame_present),
        .frame_length      (frame_length),
        .enc_field         (enc_field),
        .speed_rpm         (speed_rpm),
        .motor_current     (motor_current),
        .frame_time_ms     (frame_time_ms),
        .now_ms            (now_ms),
        .write_target      (write_target),
        .requested_current (requested_current),
        .cur_limit         (cur_limit_reg),
        .timeout_ms        (timeout_ms_reg),
        .last_enc          (last_enc_reg),
        .angle             (angle_reg),
        .speed             (speed_reg),
        .current           (current_reg),
        .last_time         (last_time_reg),
        .seen              (seen_reg),
        .target            (target_reg),
        .accepted          (accepted),
        .online            (online),
        .last_enc_next     (last_enc_next),
        .angle_next        (angle_next),
        .speed_next        (speed_next),
        .current_next      (current_next),
        .last_time_next    (last_time_next),
        .seen_next         (seen_next),
        .target_next       (target_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_enc_reg  <= '0;
            angle_reg     <= '0;
            speed_reg     <= '0;
            current_reg   <= '0;
            last_time_reg <= '0;
            seen_reg      <= 1'b0;
            target_reg    <= '0;
        end else if (advance) begin
            last_enc_reg  <= last_enc_next;
            angle_reg     <= angle_next;
            speed_reg     <= speed_next;
            current_reg   <= current_next;
            last_time_reg <= last_time_next;
            seen_reg      <= seen_next;
            target_reg    <= target_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic signed [63:0] angle_wide;
    logic [16:0]        enc_wide;
    logic [mefb_pkg::M_TDATA_W-1:0] res_tdata;

    // angle is reported sign-extended or truncated to the 40-bit field
    assign angle_wide = 64'(angle_next);
    assign enc_wide   = 17'(last_enc_next);

    always_comb begin
        res_tdata = '0;
        res_tdata[mefb_pkg::M_ANG_LSB +: mefb_pkg::ANGLE_OUT_W] =
            angle_wide[mefb_pkg::ANGLE_OUT_W-1:0];
        res_tdata[mefb_pkg::M_SPD_LSB +: mefb_pkg::SPEED_W] = speed_next;
        res_tdata[mefb_pkg::M_CUR_LSB +: 16]                = current_next;
        res_tdata[mefb_pkg::M_POS_LSB +: mefb_pkg::POS_W]   = enc_wide[mefb_pkg::POS_W-1:0];
        res_tdata[mefb_pkg::M_SEEN_BIT]                     = seen_next;
        res_tdata[mefb_pkg::M_ONL_BIT]                      = online;
        res_tdata[mefb_pkg::M_TGT_LSB +: 16]                = target_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_tdata_reg <= res_tdata;
            out_tuser_reg <= accepted;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule

[hw/rtl/mefb_update.sv]
module mefb_update #(
    parameter int ENC_COUNTS = mefb_pkg::ENC_COUNTS_DEF,
    parameter int ANGLE_BITS = mefb_pkg::ANGLE_BITS_DEF,
    localparam int ENC_W     = $clog2(ENC_COUNTS)
) (
    // item fields
    input  logic                         frame_present,
    input  logic [3:0]                   frame_length,
    input  logic [15:0]                  enc_field,
    input  logic signed [15:0]           speed_rpm,
    input  logic signed [15:0]           motor_current,
    input  logic [31:0]                  frame_time_ms,
    input  logic [31:0]                  now_ms,
    input  logic                         write_target,
    input  logic signed [15:0]           requested_current,
    // registers
    input  logic [14:0]                  cur_limit,
    input  logic [15:0]                  timeout_ms,
    // present state
    input  logic [ENC_W-1:0]             last_enc,
    input  logic signed [ANGLE_BITS-1:0] angle,
    input  logic signed [mefb_pkg::SPEED_W-1:0] speed,
    input  logic signed [15:0]           current,
    input  logic [31:0]                  last_time,
    input  logic                         seen,
    input  logic signed [15:0]           target,
    // next state and per-item flags
    output logic                         accepted,
    output logic                         online,
    output logic [ENC_W-1:0]             last_enc_next,
    output logic signed [ANGLE_BITS-1:0] angle_next,
    output logic signed [mefb_pkg::SPEED_W-1:0] speed_next,
    output logic signed [15:0]           current_next,
    output logic [31:0]                  last_time_next,
    output logic                         seen_next,
    output logic signed [15:0]           target_next
);

    localparam logic signed [17:0] HALF_S   = 18'(ENC_COUNTS / 2);
    localparam logic signed [17:0] COUNTS_S = 18'(ENC_COUNTS);
    localparam logic signed [ANGLE_BITS-1:0] ANG_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
    localparam logic signed [ANGLE_BITS-1:0] ANG_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic signed [17:0]           diff;
    logic signed [17:0]           delta;
    logic signed [ANGLE_BITS:0]   sum;
    logic signed [ANGLE_BITS-1:0] angle_step;
    logic signed [18:0]           spd_ext;
    logic signed [15:0]           lim;
    logic [31:0]                  age;

    assign accepted = frame_present && (frame_length == mefb_pkg::FRAME_LEN_OK)
                      && ({1'b0, enc_field} < 17'(ENC_COUNTS));

    // shortest way round the single turn
    assign diff = signed'({2'b00, enc_field}) - signed'(18'(last_enc));

    always_comb begin
        if (diff > HALF_S) begin
            delta = diff - COUNTS_S;
        end else if (diff < -HALF_S) begin
            delta = diff + COUNTS_S;
        end else begin
            delta = diff;
        end
    end

    // saturating accumulate, overflow shows as disagreeing top bits
    assign sum = (ANGLE_BITS+1)'(angle) + (ANGLE_BITS+1)'(delta);

    always_comb begin
        if (sum[ANGLE_BITS] != sum[ANGLE_BITS-1]) begin
            angle_step = sum[ANGLE_BITS] ? ANG_MIN : ANG_MAX;
        end else begin
            angle_step = sum[ANGLE_BITS-1:0];
        end
    end

    assign spd_ext = 19'(speed_rpm);

    always_comb begin
        last_enc_next  = last_enc;
        angle_next     = angle;
        speed_next     = speed;
        current_next   = current;
        last_time_next = last_time;
        seen_next      = seen;
        if (accepted) begin
            last_enc_next  = enc_field[ENC_W-1:0];
            angle_next     = seen ? angle_step : signed'(ANGLE_BITS'({1'b0, enc_field}));
            speed_next     = (spd_ext <<< 2) + (spd_ext <<< 1);
            current_next   = motor_current;
            last_time_next = frame_time_ms;
            seen_next      = 1'b1;
        end
    end

    // drive target clamp
    assign lim = signed'({1'b0, cur_limit});

    always_comb begin
        target_next = target;
        if (write_target) begin
            if (requested_current > lim) begin
                target_next = lim;
            end else if (requested_current < -lim) begin
                target_next = -lim;
            end else begin
                target_next = requested_current;
            end
        end
    end

    // age wraps modulo 2^32
    assign age    = now_ms - last_time_next;
    assign online = seen_next && (age < {16'b0, timeout_ms});

endmodule

[dv/tb_top.sv]
module tb_top;
    import mefb_pkg::*;

    // cycles with no stream transfer or register access before the run is abandoned;
    // this lies well above the long receiver hold-off and the widest idle burst
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     PRINT_CAP      = 100;
    localparam int     HOLD_OFF_LEN   = 64;
    localparam int     ITEMS_PER_PASS = 200;
    localparam int     RANDOM_PASSES  = 7;
    localparam longint ANGLE_HI       = (64'sd1 <<< (ANGLE_BITS_DEF - 1)) - 1;
    localparam longint ANGLE_LO       = -ANGLE_HI - 1;

    // one feedback item as the sender sees it
    typedef struct {
        bit                 present;
        logic [3:0]         len;
        logic [15:0]        enc;
        logic signed [15:0] rpm;
        logic signed [15:0] cur;
        logic [31:0]        ftime;
        logic [31:0]        now;
        bit                 wr;
        logic signed [15:0] req;
    } fb_item_t;

    // one tracker report as the receiver sees it
    typedef struct {
        bit                 accepted;
        logic signed [39:0] angle;
        logic signed [18:0] speed;
        logic signed [15:0] cur;
        logic [12:0]        pos;
        bit                 seen;
        bit                 online;
        logic signed [15:0] target;
    } fb_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // shadow of the registers and of the tracking state, as after reset
    logic [14:0]          cur_limit_q   = CUR_LIMIT_RST;
    logic [15:0]          timeout_q     = TIMEOUT_MS_RST;
    logic [12:0]          enc_last_q    = '0;
    longint               angle_q       = 0;
    logic signed [18:0]   speed_q       = '0;
    logic signed [15:0]   current_q     = '0;
    logic [31:0]          frame_time_q  = '0;
    bit                   seen_q        = 1'b0;
    logic signed [15:0]   target_q      = '0;

    fb_result_t           pending_results[$];
    int unsigned          mismatch_cnt  = 0;
    int unsigned          result_idx    = 0;
    int unsigned          quiet_cycles  = 0;
    bit                   idling_on     = 1'b1;
    int unsigned          hold_off_len  = 0;
    logic [31:0]          ms_clock      = '0;

    multiturn_encoder_feedback_tracker_top dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // tracker prediction: applies one item, accepted or not, to the shadow state and
    // returns the report that the block must give for it
    // ------------------------------------------------------------------
    function automatic fb_result_t track_feedback(fb_item_t it);
        fb_result_t r;
        int         step;
        int         lim;
        int         want_cur;
        longint     sum;
        logic [31:0] age;
        r.accepted = it.present && it.len == FRAME_LEN_OK && it.enc < ENC_COUNTS_DEF;
        if (r.accepted) begin
            if (!seen_q) begin
                // first good frame just loads the encoder value
                angle_q = longint'(it.enc);
            end else begin
                // shortest way round the turn, half a turn kept as it is
                step = int'(it.enc) - int'(enc_last_q);
                if (step > ENC_COUNTS_DEF / 2) step -= ENC_COUNTS_DEF;
                else if (step < -(ENC_COUNTS_DEF / 2)) step += ENC_COUNTS_DEF;
                sum = angle_q + step;
                angle_q = (sum > ANGLE_HI) ? ANGLE_HI : (sum < ANGLE_LO) ? ANGLE_LO : sum;
            end
            enc_last_q   = it.enc[12:0];
            speed_q      = 19'(int'(it.rpm) * 6);
            current_q    = it.cur;
            frame_time_q = it.ftime;
            seen_q       = 1'b1;
        end
        if (it.wr) begin
            lim      = int'(cur_limit_q);
            want_cur = int'(it.req);
            if (want_cur > lim) target_q = 16'(lim);
            else if (want_cur < -lim) target_q = 16'(-lim);
            else target_q = it.req;
        end
        // age wraps modulo 2^32, a zero timeout is never met
        age      = it.now - frame_time_q;
        r.online = seen_q && (age < {16'd0, timeout_q});
        r.angle  = angle_q[39:0];
        r.speed  = speed_q;
        r.cur    = current_q;
        r.pos    = enc_last_q;
        r.seen   = seen_q;
        r.target = target_q;
        return r;
    endfunction

    function automatic fb_item_t frame_item(bit present, int len, int enc, int rpm, int cur,
                                            logic [31:0] ftime, logic [31:0] now,
                                            bit wr, int want_cur);
        fb_item_t it;
        it.present = present;
        it.len     = 4'(len);
        it.enc     = 16'(enc);
        it.rpm     = 16'(rpm);
        it.cur     = 16'(cur);
        it.ftime   = ftime;
        it.now     = now;
        it.wr      = wr;
        it.req     = 16'(want_cur);
        return it;
    endfunction

    // mostly well-formed frames walking the encoder round, with some noise
    function automatic fb_item_t random_item();
        fb_item_t    it;
        int unsigned kind;
        int          step;
        it.present = 1'b1;
        it.len     = FRAME_LEN_OK;
        it.rpm     = 16'($urandom);
        it.cur     = 16'($urandom);
        it.wr      = ($urandom_range(0, 2) == 0);
        ms_clock   = ms_clock + $urandom_range(0, 40);
        it.ftime   = ($urandom_range(0, 19) == 0) ? 32'($urandom) : ms_clock;
        kind       = $urandom_range(0, 99);
        if (kind < 58) begin
            // small move either way, crossing zero now and then
            step   = int'($urandom_range(0, 400)) - 200;
            it.enc = 16'((int'(enc_last_q) + step) & (ENC_COUNTS_DEF - 1));
        end else if (kind < 72) begin
            it.enc = 16'($urandom_range(0, ENC_COUNTS_DEF - 1));
        end else if (kind < 82) begin
            // moves around half a turn, either side of the wrap decision
            step   = int'($urandom_range(ENC_COUNTS_DEF / 2 - 3, ENC_COUNTS_DEF / 2 + 3));
            step   = $urandom_range(0, 1) ? step : -step;
            it.enc = 16'((int'(enc_last_q) + step) & (ENC_COUNTS_DEF - 1));
        end else if (kind < 88) begin
            it.present = 1'b0;
            it.len     = 4'($urandom_range(0, 8));
            it.enc     = 16'($urandom);
        end else if (kind < 94) begin
            it.len = 4'($urandom_range(0, 7));
            it.enc = 16'($urandom);
        end else begin
            it.enc = 16'($urandom_range(ENC_COUNTS_DEF, 65535));
        end
        case ($urandom_range(0, 3))
            0:       it.req = 16'(int'(cur_limit_q) + int'($urandom_range(0, 2)) - 1);
            1:       it.req = 16'(-int'(cur_limit_q) - int'($urandom_range(0, 2)) + 1);
            default: it.req = 16'($urandom);
        endcase
        // present time: mostly near the timeout boundary of this frame
        case ($urandom_range(0, 7))
            0:       it.now = $urandom;
            1:       it.now = it.ftime + timeout_q - 32'd1;
            2:       it.now = it.ftime + timeout_q;
            default: it.now = it.ftime + $urandom_range(0, 2 * timeout_q);
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------

    // offers one item, optionally after an idle burst, and returns once it is taken
    task automatic send_item(fb_item_t it);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_LEN_LSB +: 4]  = it.len;
        word[S_ENC_LSB +: 16] = it.enc;
        word[S_SPD_LSB +: 16] = it.rpm;
        word[S_CUR_LSB +: 16] = it.cur;
        word[S_FTM_LSB +: 32] = it.ftime;
        word[S_NOW_LSB +: 32] = it.now;
        word[S_REQ_LSB +: 16] = it.req;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tdata  <= word;
        s_tuser  <= {it.wr, it.present};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(track_feedback(it));
    endtask

    // stops offering and waits for every outstanding report
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_CUR_LIMIT) cur_limit_q = value[14:0];
        else timeout_q = value[15:0];
    endtask

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset values: clamp at 30000, nothing online before the first frame
    task automatic test_reset_defaults();
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd0, 1, 32767));
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd0, 1, -32768));
        send_item(frame_item(0, 0, 0, 0, 0, 32'd0, 32'd100, 0, 123));
        wait_drained();
    endtask

    // rejections, first load, wrap either side of half a turn, age boundaries
    task automatic test_frame_tracking();
        // rejected before any feedback: short length, encoder at and far past a turn
        send_item(frame_item(1, 7, 100, 5, 5, 32'd1000, 32'd1000, 0, 0));
        send_item(frame_item(1, 8, 8192, 5, 5, 32'd1000, 32'd1000, 0, 0));
        send_item(frame_item(1, 8, 65535, 5, 5, 32'd1000, 32'd1000, 0, 0));
        // first good frame loads the angle, field extremes
        send_item(frame_item(1, 8, 8191, 32767, -32768, 32'd1000, 32'd1000, 0, 0));
        // exactly half a turn down and up stays as it is
        send_item(frame_item(1, 8, 4095, -32768, 32767, 32'd1010, 32'd1010, 0, 0));
        send_item(frame_item(1, 8, 0, 0, 0, 32'd1020, 32'd1020, 0, 0));
        send_item(frame_item(1, 8, 4096, 1, -1, 32'd1030, 32'd1030, 0, 0));
        send_item(frame_item(1, 8, 8191, -1, 1, 32'd1040, 32'd1040, 0, 0));
        // one past half a turn wraps the other way
        send_item(frame_item(1, 8, 4094, 100, 200, 32'd1050, 32'd1050, 0, 0));
        send_item(frame_item(1, 8, 0, 100, 200, 32'd1060, 32'd1060, 0, 0));
        send_item(frame_item(1, 8, 4097, 100, 200, 32'd1070, 32'd1070, 0, 0));
        send_item(frame_item(1, 8, 0, 100, 200, 32'd1080, 32'd1080, 0, 0));
        // absent and rejected frames hold every field
        send_item(frame_item(0, 8, 10, 9, 9, 32'd2000, 32'd1579, 0, 0));
        send_item(frame_item(1, 8, 65535, 9, 9, 32'd2000, 32'd1580, 0, 0));
        // timestamp wrap: frame just below 2^32, present time just past it
        send_item(frame_item(1, 8, 5, 7, 7, 32'hFFFF_FFF0, 32'h0000_0010, 0, 0));
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'hFFFF_FFEF, 0, 0));
        wait_drained();
    endtask

    // register extremes, including a zero timeout that never reports online
    task automatic test_register_extremes();
        write_reg(REG_CUR_LIMIT, 32'd0);
        write_reg(REG_TIMEOUT_MS, 32'd1);
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd500, 1, 32767));
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd500, 1, -32768));
        send_item(frame_item(1, 8, 1, 0, 0, 32'd500, 32'd500, 0, 0));
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd501, 0, 0));
        wait_drained();
        write_reg(REG_CUR_LIMIT, 32'd32767);
        write_reg(REG_TIMEOUT_MS, 32'd65535);
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd500, 1, -32768));
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd500, 1, 32767));
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd66034, 0, 0));
        send_item(frame_item(0, 8, 0, 0, 0, 32'd0, 32'd66035, 0, 0));
        wait_drained();
        write_reg(REG_TIMEOUT_MS, 32'd0);
        send_item(frame_item(1, 8, 2, 0, 0, 32'd700, 32'd700, 1, 1000));
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        write_reg(REG_TIMEOUT_MS, 32'd300);
        idling_on    = 1'b0;
        hold_off_len = HOLD_OFF_LEN;
        ms_clock     = $urandom;
        repeat (40) send_item(random_item());
        wait_drained();
        idling_on = 1'b1;
    endtask

    // random passes, each under a fresh register setting; the last has no idling
    task automatic test_random_traffic();
        logic [31:0] cur_lim;
        logic [31:0] tmo;
        ms_clock = $urandom;
        for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
            case ($urandom_range(0, 4))
                0:       cur_lim = 32'd0;
                1:       cur_lim = 32'd32767;
                default: cur_lim = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 5))
                0:       tmo = 32'd1;
                1:       tmo = 32'd65535;
                default: tmo = $urandom_range(2, 300);
            endcase
            write_reg(REG_CUR_LIMIT, cur_lim);
            write_reg(REG_TIMEOUT_MS, tmo);
            idling_on = (pass != RANDOM_PASSES - 1);
            repeat (ITEMS_PER_PASS) send_item(random_item());
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // receiver readiness: random stall bursts, or one long counted hold-off
    // when a test asks for it; at most one assignment per edge
    // ------------------------------------------------------------------
    initial begin
        int unsigned n;
        forever begin
            @(posedge aclk);
            if (hold_off_len != 0) begin
                n            = hold_off_len;
                hold_off_len = 0;
                m_tready    <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end else if (idling_on && aresetn && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // report check: every result transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : report_check
        fb_result_t got;
        fb_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.accepted = m_tuser[0];
            got.angle    = m_tdata[M_ANG_LSB +: ANGLE_OUT_W];
            got.speed    = m_tdata[M_SPD_LSB +: SPEED_W];
            got.cur      = m_tdata[M_CUR_LSB +: 16];
            got.pos      = m_tdata[M_POS_LSB +: POS_W];
            got.seen     = m_tdata[M_SEEN_BIT];
            got.online   = m_tdata[M_ONL_BIT];
            got.target   = m_tdata[M_TGT_LSB +: 16];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          result_idx));
            end else begin
                want = pending_results.pop_front();
                if (got.accepted != want.accepted)
                    report_mismatch($sformatf("result %0d frame_accepted %0d, want %0d",
                                              result_idx, got.accepted, want.accepted));
                if (got.angle != want.angle)
                    report_mismatch($sformatf("result %0d angle_counts %0d, want %0d",
                                              result_idx, got.angle, want.angle));
                if (got.speed != want.speed)
                    report_mismatch($sformatf("result %0d speed_deg %0d, want %0d",
                                              result_idx, got.speed, want.speed));
                if (got.cur != want.cur)
                    report_mismatch($sformatf("result %0d current_out %0d, want %0d",
                                              result_idx, got.cur, want.cur));
                if (got.pos != want.pos)
                    report_mismatch($sformatf("result %0d encoder_position %0d, want %0d",
                                              result_idx, got.pos, want.pos));
                if (got.seen != want.seen)
                    report_mismatch($sformatf("result %0d feedback_seen %0d, want %0d",
                                              result_idx, got.seen, want.seen));
                if (got.online != want.online)
                    report_mismatch($sformatf("result %0d online %0d, want %0d",
                                              result_idx, got.online, want.online));
                if (got.target != want.target)
                    report_mismatch($sformatf("result %0d drive_tgt %0d, want %0d",
                                              result_idx, got.target, want.target));
            end
            result_idx++;
        end
    end

    // watchdog: consecutive cycles with no transfer on either channel and no register access
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[multiturn_encoder_feedback_tracker_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence: reset once, then each test in turn
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_frame_tracking();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (mismatch_cnt == 0) begin
            $display("[multiturn_encoder_feedback_tracker_top] OK");
        end else begin
            $display("[multiturn_encoder_feedback_tracker_top] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mefb_pkg.sv
hw/rtl/mefb_update.sv
hw/rtl/multiturn_encoder_feedback_tracker_top.sv
dv/tb_top.sv
